>>> rtl/bss_pkg.sv
// ============================================================================
// bss_pkg
// Shared types and fixed constants of the B-spline segment sampler.
// ============================================================================
package bss_pkg;

    // Width of the minimum spacing register (unsigned Q11.4).
    localparam int MIN_DIST_BITS = 15;

    // Per-segment flags that travel with a segment setup record.
    typedef struct packed {
        logic first_seg;
        logic final_seg;
    } seg_flags_t;

endpackage

>>> rtl/bss_if.sv
// ============================================================================
// bss_if
// Valid/ready channels of the sampler: segment in, sample out, config write.
// ============================================================================

// Segment channel: three control points and the curve flags.
interface bss_seg_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] p0_x;
    logic signed [COORD_BITS-1:0] p0_y;
    logic signed [COORD_BITS-1:0] p1_x;
    logic signed [COORD_BITS-1:0] p1_y;
    logic signed [COORD_BITS-1:0] p2_x;
    logic signed [COORD_BITS-1:0] p2_y;
    logic                         first_segment;
    logic                         final_segment;

    modport source (
        output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, first_segment, final_segment,
        input  ready
    );
    modport sink (
        input  valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, first_segment, final_segment,
        output ready
    );
endinterface

// Sample channel: one evaluated point with its filter and run flags.
interface bss_smp_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic                         kept;
    logic                         last_of_run;

    modport source (output valid, out_x, out_y, kept, last_of_run, input ready);
    modport sink   (input valid, out_x, out_y, kept, last_of_run, output ready);
endinterface

// Configuration channel: write data of the minimum spacing register.
interface bss_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bss_pkg::MIN_DIST_BITS-1:0]  min_dist;

    modport source (output valid, min_dist, input ready);
    modport sink   (input valid, min_dist, output ready);
endinterface

>>> rtl/bss_div.sv
// ============================================================================
// bss_div
// Floor division of a signed value by a fixed divisor through a reciprocal
// multiplication, with a quotient step followed by a remainder step. Gives
// the floor quotient (low bits only) and the nonnegative remainder.
// ============================================================================
module bss_div #(
    parameter  int DW      = 24,
    parameter  int QW      = 16,
    parameter  int DIVISOR = 800,
    localparam int RB      = $clog2(DIVISOR)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] dividend,
    output logic                 busy,
    output logic [QW-1:0]        quo,
    output logic [RB-1:0]        rem
);

    // Magnitude bits, reciprocal shift, reciprocal width and quotient width.
    // With K = UW + RB the rounded-up reciprocal is exact for every magnitude.
    localparam int UW  = DW - 1;
    localparam int K   = UW + RB;
    localparam int MW  = UW + 2;
    localparam int QFW = UW + MW - K;
    localparam longint unsigned RECIP =
        ((64'd1 << K) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MW-1:0] RECIP_M = MW'(RECIP);
    localparam logic [UW-1:0] DIV_UW  = UW'(DIVISOR);
    localparam logic [RB-1:0] DIV_M1  = RB'(DIVISOR - 1);
    localparam logic [1:0]    PH_QUO  = 2'd2;
    localparam logic [1:0]    PH_REM  = 2'd1;

    logic             neg_reg;
    logic [UW-1:0]    mag_reg;
    logic [QFW-1:0]   q_reg;
    logic [RB-1:0]    r_reg;
    logic [1:0]       cnt_reg;

    logic [UW-1:0]    mag;
    logic [UW+MW-1:0] prod;
    logic [UW-1:0]    back_prod;
    logic [UW-1:0]    r_full;
    logic [QW-1:0]    q_ext;

    // A negative value is divided as its complement; the result is mapped back.
    assign mag       = dividend[DW-1] ? ~dividend[UW-1:0] : dividend[UW-1:0];
    assign prod      = mag_reg * RECIP_M;
    assign back_prod = UW'(q_reg) * DIV_UW;
    assign r_full    = mag_reg - back_prod;

    // Phase counter: quotient cycle, then remainder cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= PH_QUO;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Magnitude, quotient and remainder registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[DW-1];
            mag_reg <= mag;
        end
        else if (cnt_reg == PH_QUO)
        begin
            q_reg <= prod[UW+MW-1:K];
        end
        else if (cnt_reg == PH_REM)
        begin
            r_reg <= RB'(r_full);
        end
    end

    assign q_ext = QW'(q_reg);
    assign busy  = cnt_reg != '0;
    assign quo   = neg_reg ? ~q_ext : q_ext;
    assign rem   = neg_reg ? (DIV_M1 - r_reg) : r_reg;

endmodule

>>> rtl/bss_front.sv
// ============================================================================
// bss_front
// Accepts a segment and builds its setup record: the start sample and the
// first and second forward differences, each as quotient and remainder of
// the fixed denominator 2*N^2.
// ============================================================================
module bss_front #(
    parameter  int SAMPLES_PER_SEGMENT = 20,
    parameter  int COORD_BITS          = 16,
    localparam int RB    = $clog2(2 * SAMPLES_PER_SEGMENT * SAMPLES_PER_SEGMENT),
    localparam int REC_W = 2 + 2 * (3 * COORD_BITS + 3 * RB)
) (
    input  logic             clk,
    input  logic             rst_n,
    bss_seg_if.sink          seg,
    output logic             push_valid,
    input  logic             push_ready,
    output logic [REC_W-1:0] push_data
);
    import bss_pkg::*;

    localparam int N     = SAMPLES_PER_SEGMENT;
    localparam int C     = COORD_BITS;
    localparam int DENOM = 2 * N * N;
    localparam int DW    = C + $clog2(2 * N) + 2;
    localparam logic signed [DW-1:0] TWO_N = DW'(2 * N);
    localparam logic [RB-1:0]        HALF  = RB'(N * N);

    typedef enum logic [1:0] {F_IDLE, F_PREP, F_DIV, F_PUSH} fstate_t;

    fstate_t            state_reg, state_next;
    seg_flags_t         flags_reg;
    logic signed [C-1:0] ax_reg, bx_reg, cx_reg, ay_reg, by_reg, cy_reg;

    logic               accept;
    logic               div_start;
    logic               busy_d1x, busy_d2x, busy_d1y, busy_d2y;
    logic signed [DW-1:0] d1x, d2x, d1y, d2y;
    logic signed [DW-1:0] ex, ey, ambx, amby;
    logic signed [C:0]    s0x, s0y;
    logic [C-1:0]         q1x, q2x, q1y, q2y;
    logic [RB-1:0]        r1x, r2x, r1y, r2y;
    logic [RB-1:0]        r0x, r0y;

    assign seg.ready = state_reg == F_IDLE;
    assign accept    = seg.valid && seg.ready;
    assign div_start = state_reg == F_PREP;

    // Control sequence: latch, start the dividers, wait, hand over the record.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_PREP;
                end
            end
            F_PREP:
            begin
                state_next = F_DIV;
            end
            F_DIV:
            begin
                if (!(busy_d1x || busy_d2x || busy_d1y || busy_d2y))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control points of the segment being prepared.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg    <= seg.p0_x;
            bx_reg    <= seg.p1_x;
            cx_reg    <= seg.p2_x;
            ay_reg    <= seg.p0_y;
            by_reg    <= seg.p1_y;
            cy_reg    <= seg.p2_y;
            flags_reg <= '{first_seg: seg.first_segment, final_seg: seg.final_segment};
        end
    end

    // Differences: d1 = (P0 - 2P1 + P2) - 2N(P0 - P1), d2 = 2(P0 - 2P1 + P2).
    always_comb
    begin
        ambx = DW'(ax_reg) - DW'(bx_reg);
        amby = DW'(ay_reg) - DW'(by_reg);
        ex   = DW'(ax_reg) - (DW'(bx_reg) + DW'(bx_reg)) + DW'(cx_reg);
        ey   = DW'(ay_reg) - (DW'(by_reg) + DW'(by_reg)) + DW'(cy_reg);
        d1x  = ex - ambx * TWO_N;
        d1y  = ey - amby * TWO_N;
        d2x  = ex + ex;
        d2y  = ey + ey;
    end

    // Start sample: (P0 + P1 + 1) / 2 exactly, remainder N^2 when odd.
    assign s0x = (C + 1)'(ax_reg) + (C + 1)'(bx_reg) + (C + 1)'(1);
    assign s0y = (C + 1)'(ay_reg) + (C + 1)'(by_reg) + (C + 1)'(1);
    assign r0x = s0x[0] ? HALF : '0;
    assign r0y = s0y[0] ? HALF : '0;

    bss_div #(.DW(DW), .QW(C), .DIVISOR(DENOM)) u_div_d1x (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(d1x),
        .busy(busy_d1x), .quo(q1x), .rem(r1x)
    );
    bss_div #(.DW(DW), .QW(C), .DIVISOR(DENOM)) u_div_d2x (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(d2x),
        .busy(busy_d2x), .quo(q2x), .rem(r2x)
    );
    bss_div #(.DW(DW), .QW(C), .DIVISOR(DENOM)) u_div_d1y (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(d1y),
        .busy(busy_d1y), .quo(q1y), .rem(r1y)
    );
    bss_div #(.DW(DW), .QW(C), .DIVISOR(DENOM)) u_div_d2y (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(d2y),
        .busy(busy_d2y), .quo(q2y), .rem(r2y)
    );

    // Setup record: flags, then x and y, each as start, first and second step.
    assign push_valid = state_reg == F_PUSH;
    assign push_data  = {flags_reg,
                         s0x[C:1], r0x, q1x, r1x, q2x, r2x,
                         s0y[C:1], r0y, q1y, r1y, q2y, r2y};

endmodule

>>> rtl/bss_queue.sv
// ============================================================================
// bss_queue
// Small first-in first-out buffer of segment setup records between the
// front and the back.
// ============================================================================
module bss_queue #(
    parameter int W     = 130,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Record storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/bss_back.sv
// ============================================================================
// bss_back
// Steps through the samples of a segment by forward differencing in
// quotient and remainder form, applies the spacing filter against the last
// kept point and holds the result in an output register.
// ============================================================================
module bss_back #(
    parameter  int SAMPLES_PER_SEGMENT = 20,
    parameter  int COORD_BITS          = 16,
    localparam int RB    = $clog2(2 * SAMPLES_PER_SEGMENT * SAMPLES_PER_SEGMENT),
    localparam int REC_W = 2 + 2 * (3 * COORD_BITS + 3 * RB)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  logic [REC_W-1:0] pop_data,
    bss_smp_if.source        sample,
    bss_cfg_if.sink          cfg
);
    import bss_pkg::*;

    localparam int N  = SAMPLES_PER_SEGMENT;
    localparam int C  = COORD_BITS;
    localparam int JW = $clog2(N + 1);
    localparam int MD = MIN_DIST_BITS;
    localparam int CW = (C > MD) ? C : MD;
    localparam logic [RB:0] D_EXT = (RB + 1)'(2 * N * N);

    typedef enum logic {B_IDLE, B_RUN} bstate_t;

    // Adds a step to a value, both held as quotient and remainder of 2*N^2.
    function automatic logic [C+RB-1:0] mix_add(
        input logic [C-1:0]  q,
        input logic [RB-1:0] r,
        input logic [C-1:0]  dq,
        input logic [RB-1:0] dr
    );
        logic [RB:0] rs;
        logic        carry;
        rs    = {1'b0, r} + {1'b0, dr};
        carry = rs >= D_EXT;
        if (carry)
        begin
            rs = rs - D_EXT;
        end
        return {q + dq + C'(carry), rs[RB-1:0]};
    endfunction

    // Unpacked setup record from the queue.
    seg_flags_t    rec_flags;
    logic [C-1:0]  rq0x, rq1x, rq2x, rq0y, rq1y, rq2y;
    logic [RB-1:0] rr0x, rr1x, rr2x, rr0y, rr1y, rr2y;

    assign {rec_flags,
            rq0x, rr0x, rq1x, rr1x, rq2x, rr2x,
            rq0y, rr0y, rq1y, rr1y, rq2y, rr2y} = pop_data;

    // Sequencer state and difference engine.
    bstate_t       state_reg, state_next;
    logic [JW-1:0] j_reg, j_next;
    seg_flags_t    flags_reg, flags_next;
    logic [C-1:0]  qx_reg, qx_next, dqx_reg, dqx_next, ddqx_reg, ddqx_next;
    logic [RB-1:0] rx_reg, rx_next, drx_reg, drx_next, ddrx_reg, ddrx_next;
    logic [C-1:0]  qy_reg, qy_next, dqy_reg, dqy_next, ddqy_reg, ddqy_next;
    logic [RB-1:0] ry_reg, ry_next, dry_reg, dry_next, ddry_reg, ddry_next;

    // Sample stage.
    logic          s_valid_reg, s_valid_next;
    logic [C-1:0]  s_x_reg, s_x_next, s_y_reg, s_y_next;
    logic          s_last_reg, s_last_next, s_clr_reg, s_clr_next;

    // Filter state and output register.
    logic          have_reg, have_next;
    logic [C-1:0]  lk_x_reg, lk_x_next, lk_y_reg, lk_y_next;
    logic          out_valid_reg, out_valid_next;
    logic [C-1:0]  out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic          out_kept_reg, out_kept_next, out_last_reg, out_last_next;

    // Configuration.
    logic [MD-1:0]   min_dist_reg;
    logic [2*MD-1:0] min_sq_reg;

    logic            advance, is_last, load, emit;
    logic signed [C:0] dx, dy;
    logic [C-1:0]    ax, ay;
    logic [MD-1:0]   axs, ays;
    logic [2*MD-1:0] sqx, sqy;
    logic [2*MD:0]   dist_sq;
    logic            far, keep, hp;

    assign advance   = !out_valid_reg || sample.ready;
    assign is_last   = j_reg == (flags_reg.final_seg ? JW'(N) : JW'(N - 1));
    assign load      = pop_valid && (state_reg == B_IDLE || (state_reg == B_RUN && advance
                                                                && is_last));
    assign emit      = state_reg == B_RUN && advance;
    assign pop_ready = load;

    // Spacing filter: per-axis coarse test, then squared distance.
    always_comb
    begin
        dx      = (C + 1)'($signed(s_x_reg)) - (C + 1)'($signed(lk_x_reg));
        dy      = (C + 1)'($signed(s_y_reg)) - (C + 1)'($signed(lk_y_reg));
        ax      = dx[C] ? C'(-dx) : C'(dx);
        ay      = dy[C] ? C'(-dy) : C'(dy);
        axs     = MD'(ax);
        ays     = MD'(ay);
        sqx     = axs * axs;
        sqy     = ays * ays;
        dist_sq = {1'b0, sqx} + {1'b0, sqy};
        far     = (CW'(ax) > CW'(min_dist_reg)) || (CW'(ay) > CW'(min_dist_reg))
                  || (dist_sq > {1'b0, min_sq_reg});
        hp      = have_reg && !s_clr_reg;
        keep    = !hp || far;
    end

    // Next-state logic of all three stages.
    always_comb
    begin
        state_next     = state_reg;
        j_next         = j_reg;
        flags_next     = flags_reg;
        qx_next        = qx_reg;
        rx_next        = rx_reg;
        dqx_next       = dqx_reg;
        drx_next       = drx_reg;
        ddqx_next      = ddqx_reg;
        ddrx_next      = ddrx_reg;
        qy_next        = qy_reg;
        ry_next        = ry_reg;
        dqy_next       = dqy_reg;
        dry_next       = dry_reg;
        ddqy_next      = ddqy_reg;
        ddry_next      = ddry_reg;
        s_valid_next   = s_valid_reg;
        s_x_next       = s_x_reg;
        s_y_next       = s_y_reg;
        s_last_next    = s_last_reg;
        s_clr_next     = s_clr_reg;
        have_next      = have_reg;
        lk_x_next      = lk_x_reg;
        lk_y_next      = lk_y_reg;
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_kept_next  = out_kept_reg;
        out_last_next  = out_last_reg;

        // Emit the current sample and step to the next one.
        if (emit)
        begin
            s_valid_next = 1'b1;
            s_x_next     = qx_reg;
            s_y_next     = qy_reg;
            s_last_next  = is_last;
            s_clr_next   = flags_reg.first_seg && (j_reg == '0);
            j_next       = j_reg + 1'b1;
            {qx_next, rx_next}   = mix_add(qx_reg, rx_reg, dqx_reg, drx_reg);
            {dqx_next, drx_next} = mix_add(dqx_reg, drx_reg, ddqx_reg, ddrx_reg);
            {qy_next, ry_next}   = mix_add(qy_reg, ry_reg, dqy_reg, dry_reg);
            {dqy_next, dry_next} = mix_add(dqy_reg, dry_reg, ddqy_reg, ddry_reg);
            if (is_last)
            begin
                state_next = B_IDLE;
            end
        end
        else if (advance)
        begin
            s_valid_next = 1'b0;
        end

        // Take the next setup record.
        if (load)
        begin
            state_next = B_RUN;
            j_next     = '0;
            flags_next = rec_flags;
            qx_next    = rq0x;
            rx_next    = rr0x;
            dqx_next   = rq1x;
            drx_next   = rr1x;
            ddqx_next  = rq2x;
            ddrx_next  = rr2x;
            qy_next    = rq0y;
            ry_next    = rr0y;
            dqy_next   = rq1y;
            dry_next   = rr1y;
            ddqy_next  = rq2y;
            ddry_next  = rr2y;
        end

        // Filter the staged sample into the output register.
        if (advance)
        begin
            out_valid_next = s_valid_reg;
            if (s_valid_reg)
            begin
                out_x_next    = s_x_reg;
                out_y_next    = s_y_reg;
                out_kept_next = keep;
                out_last_next = s_last_reg;
                if (keep)
                begin
                    have_next = 1'b1;
                    lk_x_next = s_x_reg;
                    lk_y_next = s_y_reg;
                end
            end
        end
    end

    // Control state and filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            j_reg         <= '0;
            s_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            have_reg      <= 1'b0;
            lk_x_reg      <= '0;
            lk_y_reg      <= '0;
            min_dist_reg  <= '0;
            min_sq_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            s_valid_reg   <= s_valid_next;
            out_valid_reg <= out_valid_next;
            have_reg      <= have_next;
            lk_x_reg      <= lk_x_next;
            lk_y_reg      <= lk_y_next;
            if (cfg.valid)
            begin
                min_dist_reg <= cfg.min_dist;
            end
            min_sq_reg    <= min_dist_reg * min_dist_reg;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        flags_reg    <= flags_next;
        qx_reg       <= qx_next;
        rx_reg       <= rx_next;
        dqx_reg      <= dqx_next;
        drx_reg      <= drx_next;
        ddqx_reg     <= ddqx_next;
        ddrx_reg     <= ddrx_next;
        qy_reg       <= qy_next;
        ry_reg       <= ry_next;
        dqy_reg      <= dqy_next;
        dry_reg      <= dry_next;
        ddqy_reg     <= ddqy_next;
        ddry_reg     <= ddry_next;
        s_x_reg      <= s_x_next;
        s_y_reg      <= s_y_next;
        s_last_reg   <= s_last_next;
        s_clr_reg    <= s_clr_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_kept_reg <= out_kept_next;
        out_last_reg <= out_last_next;
    end

    assign cfg.ready          = 1'b1;
    assign sample.valid       = out_valid_reg;
    assign sample.out_x       = out_x_reg;
    assign sample.out_y       = out_y_reg;
    assign sample.kept        = out_kept_reg;
    assign sample.last_of_run = out_last_reg;

endmodule

>>> rtl/bspline_segment_sampler.sv
// ============================================================================
// bspline_segment_sampler
// Tessellates quadratic uniform B-spline segments into samples with a
// minimum-spacing filter against the last kept point.
//
//   Channel | Dir | Word
//   --------+-----+------------------------------------------------------
//   seg     | in  | p0..p2 x/y, first_segment, final_segment
//   sample  | out | out_x, out_y, kept, last_of_run (N or N+1 words/seg)
//   cfg     | in  | min_dist (always ready)
//
// The back emits one sample word per cycle while the sample channel is not
// stalled: a segment gives N words, N+1 on a final segment, and consecutive
// segments follow without a gap while the setup queue holds the next one.
// The front takes each segment through its states in order: accepting it,
// a setup state, a wait in its reciprocal dividers and the hand-over of
// the record to the queue. Reset clears all control state; no clearing
// pass is needed. A stalled sample channel stops the back from emitting;
// the two-entry queue lets the front keep preparing segments meanwhile.
// ============================================================================
module bspline_segment_sampler #(
    parameter int SAMPLES_PER_SEGMENT = 20,
    parameter int COORD_BITS          = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    bss_seg_if.sink    seg,
    bss_smp_if.source  sample,
    bss_cfg_if.sink    cfg
);

    localparam int RB    = $clog2(2 * SAMPLES_PER_SEGMENT * SAMPLES_PER_SEGMENT);
    localparam int REC_W = 2 + 2 * (3 * COORD_BITS + 3 * RB);

    logic             push_valid, push_ready, pop_valid, pop_ready;
    logic [REC_W-1:0] push_data, pop_data;

    // Front: segment intake and setup computation.
    bss_front #(
        .SAMPLES_PER_SEGMENT(SAMPLES_PER_SEGMENT),
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .seg(seg),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data(push_data)
    );

    // Setup record queue.
    bss_queue #(
        .W(REC_W),
        .DEPTH(2)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data(push_data),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_data(pop_data)
    );

    // Back: sample stepping, spacing filter and output register.
    bss_back #(
        .SAMPLES_PER_SEGMENT(SAMPLES_PER_SEGMENT),
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_data(pop_data),
        .sample(sample),
        .cfg(cfg)
    );

endmodule
